### hw/rtl/vbph_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vbph_pkg
// Shared types, widths and helpers for the volume-by-price histogram block.
// ----------------------------------------------------------------------------
package vbph_pkg;

    // Default sizing
    localparam int MAX_SAMPLES_DEF = 1024;
    localparam int NUM_BINS_DEF    = 12;

    // Field widths
    localparam int PRICE_W     = 32;
    localparam int VOL_W       = 32;
    localparam int SUM_W       = 42;
    localparam int EDGE_W      = 33;
    localparam int COLOR_W     = 24;
    localparam int FRAC_W      = 8;
    // Q8 price/edge width; edges stay below high*256 + bins*256
    localparam int QW          = 41;
    // Q8 bin width: ((high - low) << 8) / bins
    localparam int DIV_W       = 40;
    localparam int DIV_CNT_W   = 2;
    // Bin width divider stages: quotient, remainder, fraction
    localparam int DIV_STEPS   = 3;
    localparam int IN_TDATA_W  = 64;
    localparam int OUT_PAD_W   = 2;
    localparam int OUT_TDATA_W = 176;
    localparam int CFG_IDX_W   = 1;

    // Register defaults
    localparam logic [COLOR_W-1:0] UP_COLOR_RST   = 24'h00FF00;
    localparam logic [COLOR_W-1:0] DOWN_COLOR_RST = 24'hFF0000;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_UP_COLOR   = 1'b0,
        CFG_DOWN_COLOR = 1'b1
    } cfg_idx_t;

    // Controller states
    typedef enum logic [3:0] {
        ST_LOAD,
        ST_PREP,
        ST_DIV,
        ST_BUILD,
        ST_SCAN,
        ST_DRAIN,
        ST_EMIT_RD,
        ST_EMIT_UP,
        ST_EMIT_DN
    } vbph_state_t;

    // Controller -> datapath
    typedef struct packed {
        logic load_en;     // accept samples
        logic prep;        // restart divider, reset edge accumulator and scan address
        logic div_step;    // one divider stage
        logic bin_store;   // store edges of one bin
        logic scan_issue;  // read one stored sample
        logic edge_init;   // rewind edge accumulator for output
        logic sel_emit;    // bin store read address from output bin counter
        logic emit_up;     // load up-color bar into output register
        logic emit_down;   // load down-color bar, advance bin
        logic clear_set;   // clear count, extremes and totals
    } vbph_cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic last_valid;  // a sample flagged last is offered
        logic div_done;    // final divider stage this step
        logic bin_last;    // bin counter on last bin
        logic scan_last;   // scan address on last stored sample
        logic pipe_empty;  // binning pipeline idle
        logic out_free;    // output register can take a bar
    } vbph_sts_t;

    // Saturating 42-bit accumulate
    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                                 input logic [VOL_W-1:0] b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + {{(SUM_W + 1 - VOL_W){1'b0}}, b};
        return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
    endfunction

endpackage

### hw/rtl/vbph_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vbph_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module vbph_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Read-first: a read of the address being written returns the old word
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rd_data_reg <= mem_reg[raddr];
    end

    assign rdata = rd_data_reg;

endmodule

### hw/rtl/vbph_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vbph_ctrl
// Sequencer: load, divide, build bins, scan samples, emit bars, clear.
// ----------------------------------------------------------------------------
module vbph_ctrl
    import vbph_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  vbph_sts_t sts,
    output vbph_cmd_t cmd
);

    vbph_state_t state_reg, state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD: begin
                if (sts.last_valid) state_next = ST_PREP;
            end
            ST_PREP:  state_next = ST_DIV;
            ST_DIV: begin
                if (sts.div_done) state_next = ST_BUILD;
            end
            ST_BUILD: begin
                if (sts.bin_last) state_next = ST_SCAN;
            end
            ST_SCAN: begin
                if (sts.scan_last) state_next = ST_DRAIN;
            end
            ST_DRAIN: begin
                if (sts.pipe_empty) state_next = ST_EMIT_RD;
            end
            ST_EMIT_RD: state_next = ST_EMIT_UP;
            ST_EMIT_UP: begin
                if (sts.out_free) state_next = ST_EMIT_DN;
            end
            ST_EMIT_DN: begin
                if (sts.out_free) begin
                    state_next = sts.bin_last ? ST_LOAD : ST_EMIT_RD;
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    // Commands
    always_comb begin
        cmd = '0;
        case (state_reg)
            ST_LOAD:  cmd.load_en = 1'b1;
            ST_PREP:  cmd.prep = 1'b1;
            ST_DIV:   cmd.div_step = 1'b1;
            ST_BUILD: cmd.bin_store = 1'b1;
            ST_SCAN:  cmd.scan_issue = 1'b1;
            ST_DRAIN: cmd.edge_init = sts.pipe_empty;
            ST_EMIT_RD: cmd.sel_emit = 1'b1;
            ST_EMIT_UP: begin
                cmd.sel_emit = 1'b1;
                cmd.emit_up  = sts.out_free;
            end
            ST_EMIT_DN: begin
                cmd.sel_emit  = 1'b1;
                cmd.emit_down = sts.out_free;
                cmd.clear_set = sts.out_free && sts.bin_last;
            end
            default: cmd = '0;
        endcase
    end

endmodule

### hw/rtl/vbph_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vbph_dp
// Datapath: sample store, extremes, bin width divider, bin edges, binning
// pipeline with per-bin totals, and the output register.
// ----------------------------------------------------------------------------
module vbph_dp
    import vbph_pkg::*;
#(
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
    parameter int NUM_BINS    = NUM_BINS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  vbph_cmd_t              cmd,
    output vbph_sts_t              sts,
    input  logic                   s_tvalid,
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    input  logic                   s_tlast,
    input  logic [COLOR_W-1:0]     up_color,
    input  logic [COLOR_W-1:0]     down_color,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,
    output logic                   m_tlast
);

    localparam int AW   = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int CW   = $clog2(MAX_SAMPLES + 1);
    localparam int KW   = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
    localparam int NBW  = $clog2(NUM_BINS + 1);
    localparam int SMP_W = PRICE_W + VOL_W;
    localparam int BIN_W = 2 * SUM_W;

    // Reciprocal constants for the bin width: exact floor division for
    // dividends below 2^PRICE_W and 2^ZW respectively
    localparam int NL   = $clog2(NUM_BINS);
    localparam int SH1  = PRICE_W + NL;
    localparam int P1_W = SH1 + PRICE_W;
    localparam logic [PRICE_W:0] RCP1 =
        (PRICE_W + 1)'(((64'd1 << SH1) + 64'(NUM_BINS) - 64'd1) / 64'(NUM_BINS));
    localparam int ZW   = NBW + FRAC_W;
    localparam int SH2  = ZW + NL;
    localparam int P2_W = 2 * ZW + 1;
    localparam logic [ZW:0] RCP2 =
        (ZW + 1)'(((64'd1 << SH2) + 64'(NUM_BINS) - 64'd1) / 64'(NUM_BINS));

    // ---------------- sample load ----------------
    logic [CW-1:0]      cnt_reg;
    logic [PRICE_W-1:0] lo_reg, hi_reg;
    logic [PRICE_W-1:0] in_price;
    logic [VOL_W-1:0]   in_vol;
    logic               store_en;

    assign in_price = s_tdata[PRICE_W-1:0];
    assign in_vol   = s_tdata[SMP_W-1:PRICE_W];
    assign store_en = s_tvalid && cmd.load_en && (cnt_reg < CW'(MAX_SAMPLES));
    assign sts.last_valid = s_tvalid && s_tlast;

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clear_set) begin
            cnt_reg <= '0;
            lo_reg  <= '1;
            hi_reg  <= '0;
        end else if (store_en) begin
            cnt_reg <= cnt_reg + CW'(1);
            if (in_price < lo_reg) lo_reg <= in_price;
            if (in_price > hi_reg) hi_reg <= in_price;
        end
    end

    // Sample store, read by the scan
    logic [AW-1:0]    scan_addr_reg;
    logic [SMP_W-1:0] smp_rdata;

    vbph_ram #(
        .WIDTH (SMP_W),
        .DEPTH (MAX_SAMPLES)
    ) u_smp_ram (
        .aclk  (aclk),
        .we    (store_en),
        .waddr (cnt_reg[AW-1:0]),
        .wdata ({in_vol, in_price}),
        .raddr (scan_addr_reg),
        .rdata (smp_rdata)
    );

    // ---------------- bin width: (span << 8) / NUM_BINS ----------------
    // span = q0 * NUM_BINS + r0, so the Q8 width is {q0, (r0 << 8) / NUM_BINS}.
    // Stages: q0 by reciprocal, then r0, then the fraction by a small reciprocal.
    logic [DIV_W-1:0]     quo_reg;
    logic [PRICE_W-1:0]   q0_reg, q0_next;
    logic [NBW-1:0]       r0_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic [PRICE_W-1:0]   span;
    logic [P1_W-1:0]      prod1;
    logic [PRICE_W-1:0]   q0_mul;
    logic [ZW-1:0]        frac_num;
    logic [P2_W-1:0]      prod2;
    logic [FRAC_W-1:0]    frac_q;

    assign span     = (hi_reg >= lo_reg) ? (hi_reg - lo_reg) : '0;
    assign prod1    = P1_W'(span) * P1_W'(RCP1);
    assign q0_next  = prod1[SH1 +: PRICE_W];
    assign q0_mul   = q0_reg * PRICE_W'(NUM_BINS);
    assign frac_num = {r0_reg, {FRAC_W{1'b0}}};
    assign prod2    = P2_W'(frac_num) * P2_W'(RCP2);
    assign frac_q   = prod2[SH2 +: FRAC_W];
    assign sts.div_done = (div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1));

    always_ff @(posedge aclk) begin
        if (cmd.prep) begin
            div_cnt_reg <= '0;
        end else if (cmd.div_step) begin
            q0_reg      <= q0_next;
            r0_reg      <= NBW'(span - q0_mul);
            quo_reg     <= {q0_reg, frac_q};
            div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
        end
    end

    // ---------------- bin edges (Q8) ----------------
    logic [QW-1:0] acc_reg;
    logic [QW-1:0] acc_top, acc_step;
    logic [KW-1:0] k_reg;
    logic [QW-1:0] bot_reg [NUM_BINS];
    logic [QW-1:0] top_reg [NUM_BINS];

    assign acc_top      = acc_reg + {1'b0, quo_reg};
    assign acc_step     = acc_top + QW'(256);
    assign sts.bin_last = (k_reg == KW'(NUM_BINS - 1));

    always_ff @(posedge aclk) begin
        if (cmd.prep || cmd.edge_init) begin
            acc_reg <= {1'b0, lo_reg, {FRAC_W{1'b0}}};
            k_reg   <= '0;
        end else if (cmd.bin_store || cmd.emit_down) begin
            acc_reg <= acc_step;
            k_reg   <= sts.bin_last ? '0 : k_reg + KW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.bin_store) begin
            bot_reg[k_reg] <= acc_reg;
            top_reg[k_reg] <= acc_top;
        end
    end

    // ---------------- scan address ----------------
    assign sts.scan_last = (CW'(scan_addr_reg) + CW'(1) == cnt_reg);

    always_ff @(posedge aclk) begin
        if (cmd.prep) begin
            scan_addr_reg <= '0;
        end else if (cmd.scan_issue) begin
            scan_addr_reg <= scan_addr_reg + AW'(1);
        end
    end

    // ---------------- binning pipeline ----------------
    // P1: sample word back from the store, find its bin
    logic                v1_reg, first1_reg;
    logic [PRICE_W-1:0]  prev_reg;
    logic [PRICE_W-1:0]  p1;
    logic [VOL_W-1:0]    vol1;
    logic [QW-1:0]       p1_q;
    logic [NUM_BINS-1:0] hit;
    logic [KW-1:0]       hit_k;

    assign p1   = smp_rdata[PRICE_W-1:0];
    assign vol1 = smp_rdata[SMP_W-1:PRICE_W];
    assign p1_q = {1'b0, p1, {FRAC_W{1'b0}}};

    always_comb begin
        for (int k = 0; k < NUM_BINS; k++) begin
            hit[k] = (p1_q >= bot_reg[k]) && (p1_q <= top_reg[k]);
        end
    end

    // Lowest matching bin
    always_comb begin
        hit_k = '0;
        for (int k = NUM_BINS - 1; k >= 0; k--) begin
            if (hit[k]) hit_k = KW'(k);
        end
    end

    // P2: read totals of the bin; P3: accumulate and write back
    logic             v2_reg, up2_reg;
    logic [KW-1:0]    k2_reg;
    logic [VOL_W-1:0] vol2_reg;
    logic             v3_reg, up3_reg;
    logic [KW-1:0]    k3_reg;
    logic [VOL_W-1:0] vol3_reg;
    logic             fwd_reg;
    logic [BIN_W-1:0] fwd_data_reg;
    logic             rd_vld_reg;
    logic [NUM_BINS-1:0] vld_reg;
    logic [KW-1:0]    bin_raddr;
    logic [BIN_W-1:0] bin_rdata;
    logic [BIN_W-1:0] base;
    logic [BIN_W-1:0] sum_wdata;
    logic [SUM_W-1:0] base_up, base_dn;

    assign bin_raddr = cmd.sel_emit ? k_reg : k2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= cmd.scan_issue;
            v2_reg <= v1_reg && !first1_reg && (|hit);
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        first1_reg   <= (scan_addr_reg == '0);
        if (v1_reg) prev_reg <= p1;
        k2_reg       <= hit_k;
        vol2_reg     <= vol1;
        up2_reg      <= (p1 >= prev_reg);
        k3_reg       <= k2_reg;
        vol3_reg     <= vol2_reg;
        up3_reg      <= up2_reg;
        // Write in flight to the bin being read: pass it on
        fwd_reg      <= v3_reg && (k3_reg == k2_reg);
        fwd_data_reg <= sum_wdata;
        rd_vld_reg   <= vld_reg[bin_raddr];
    end

    assign base    = fwd_reg ? fwd_data_reg : (rd_vld_reg ? bin_rdata : '0);
    assign base_up = base[BIN_W-1:SUM_W];
    assign base_dn = base[SUM_W-1:0];
    assign sum_wdata = up3_reg ? {sat_add(base_up, vol3_reg), base_dn}
                               : {base_up, sat_add(base_dn, vol3_reg)};

    // Per-bin valid bits stand in for clearing the totals
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clear_set) begin
            vld_reg <= '0;
        end else if (v3_reg) begin
            vld_reg[k3_reg] <= 1'b1;
        end
    end

    vbph_ram #(
        .WIDTH (BIN_W),
        .DEPTH (NUM_BINS)
    ) u_bin_ram (
        .aclk  (aclk),
        .we    (v3_reg),
        .waddr (k3_reg),
        .wdata (sum_wdata),
        .raddr (bin_raddr),
        .rdata (bin_rdata)
    );

    assign sts.pipe_empty = !v1_reg && !v2_reg && !v3_reg;

    // ---------------- output register ----------------
    logic                 m_tvalid_reg;
    logic [EDGE_W-1:0]    ob_bot_reg, ob_top_reg;
    logic [SUM_W-1:0]     ob_up_reg, ob_dn_reg;
    logic [COLOR_W-1:0]   ob_color_reg;
    logic                 ob_last_reg;
    logic                 emit_any;

    assign emit_any     = cmd.emit_up || cmd.emit_down;
    assign sts.out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (emit_any) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit_any) begin
            ob_bot_reg   <= acc_reg[QW-1:FRAC_W];
            ob_top_reg   <= acc_top[QW-1:FRAC_W];
            ob_up_reg    <= rd_vld_reg ? bin_rdata[BIN_W-1:SUM_W] : '0;
            ob_dn_reg    <= rd_vld_reg ? bin_rdata[SUM_W-1:0] : '0;
            ob_color_reg <= cmd.emit_up ? up_color : down_color;
            ob_last_reg  <= cmd.emit_down && sts.bin_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = ob_last_reg;
    assign m_tdata  = {{OUT_PAD_W{1'b0}}, ob_color_reg, ob_dn_reg, ob_up_reg,
                       ob_top_reg, ob_bot_reg};

    // ---------------- assertions ----------------
    // No totals write while the store is read for output
    a_no_write_in_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        v3_reg |-> !cmd.sel_emit)
        else $error("bin totals written during output");

    // Bins are disjoint, so a price lands in at most one
    a_one_bin: assert property (@(posedge aclk) disable iff (!aresetn)
        (v1_reg && !first1_reg) |-> $onehot0(hit))
        else $error("price matched several bins");

    // Scan stays within the stored samples
    a_scan_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.scan_issue |-> (CW'(scan_addr_reg) < cnt_reg))
        else $error("scan beyond stored samples");

    // A bar never has its top below its bottom
    a_edge_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> (ob_top_reg >= ob_bot_reg))
        else $error("bin top below bottom");

endmodule

### hw/rtl/volume_by_price_histogram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// volume_by_price_histogram
// Stores a set of price/volume samples, then splits the price span into
// NUM_BINS bins and reports up and down volume per bin as two bars each.
//
//  Channel  Dir  Signals                         Transaction
//  s_       in   s_tvalid/s_tready/s_tdata/tlast one sample; tlast ends the set
//  m_       out  m_tvalid/m_tready/m_tdata/tlast one bar; tlast on last bar
//  cfg_     in   cfg_wr_en/cfg_index/cfg_wdata   write of one color register
//
//  Samples load one per cycle while the block is collecting.
//  On the last sample: a prep step, the reciprocal bin width divide, the bin
//  edges, a scan of the stored samples and a drain of the binning pipeline;
//  then, for each bin of output, a totals read, its up bar and its down bar.
//  s_tready is low from the last sample until the final bar is loaded.
//  A stalled m_tready holds the output register and the sequencer.
//  Reset is synchronous; the sample store has no clearing pass.
// ----------------------------------------------------------------------------
module volume_by_price_histogram
    import vbph_pkg::*;
#(
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
    parameter int NUM_BINS    = NUM_BINS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // input samples
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // close_price[31:0], trade_volume[63:32]
    input  logic                   s_tlast,   // final_sample
    // output bars
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // bin_bottom[32:0], bin_top[65:33],
                                              // up_total[107:66], down_total[149:108],
                                              // bar_color[173:150], zero pad
    output logic                   m_tlast,   // last_bar
    // configuration
    input  logic                   cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [COLOR_W-1:0]     cfg_wdata
);

    vbph_cmd_t          cmd;
    vbph_sts_t          sts;
    logic [COLOR_W-1:0] up_color_reg, down_color_reg;

    // Color registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            up_color_reg   <= UP_COLOR_RST;
            down_color_reg <= DOWN_COLOR_RST;
        end else if (cfg_wr_en) begin
            case (cfg_idx_t'(cfg_index))
                CFG_UP_COLOR:   up_color_reg   <= cfg_wdata;
                CFG_DOWN_COLOR: down_color_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign s_tready = cmd.load_en;

    vbph_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .sts     (sts),
        .cmd     (cmd)
    );

    vbph_dp #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .NUM_BINS    (NUM_BINS)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .sts        (sts),
        .s_tvalid   (s_tvalid),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .up_color   (up_color_reg),
        .down_color (down_color_reg),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule

### tb/volume_by_price_histogram_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// volume_by_price_histogram_test
// Self-checking bench for the volume-by-price histogram. A queue-fed driver
// streams price/volume sample sets into the block. Every accepted sample
// also goes through a bench-side histogram predictor. Each bar that leaves
// the block is checked field by field against the oldest predicted bar.
// Sender gaps and receiver stalls are random, plus one long receiver hold-off.
// Color registers are rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module volume_by_price_histogram_test;
    import vbph_pkg::*;

    localparam int    NB          = NUM_BINS_DEF;
    localparam int    DEPTH       = MAX_SAMPLES_DEF;
    localparam int    GAP_Q       = 1 << FRAC_W;   // one price unit in Q8
    localparam int    RANDOM_ITEMS = 300;
    localparam int    SETTLE      = 8;
    localparam int    HOLD_CYCLES = 800;
    localparam longint CYCLE_LIMIT = 1_000_000;

    typedef struct {
        logic [PRICE_W-1:0] price;
        logic [VOL_W-1:0]   vol;
        logic               fin;
    } sample_t;

    typedef struct {
        logic [EDGE_W-1:0]  bottom;
        logic [EDGE_W-1:0]  top;
        logic [SUM_W-1:0]   up_vol;
        logic [SUM_W-1:0]   down_vol;
        logic [COLOR_W-1:0] color;
        logic               last;
    } bar_t;

    typedef enum int {PX_WIDE, PX_NARROW, PX_FLAT} price_mode_t;

    // DUT ports
    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic                   s_tlast   = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tlast;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = CFG_UP_COLOR;
    logic [COLOR_W-1:0]     cfg_wdata = '0;

    // Bench state
    sample_t pending_samples[$];
    bar_t    expected_bars[$];
    int      error_count = 0;
    longint  cycle_count = 0;
    bit      idle_on     = 1'b0;
    logic    hold_req    = 1'b0;
    int      hold_left   = 0;
    int      send_gap    = 0;
    int      recv_wait   = 0;

    // Predictor state
    logic [PRICE_W-1:0] price_log [DEPTH];
    logic [VOL_W-1:0]   vol_log [DEPTH];
    int                 stored     = 0;
    logic [PRICE_W-1:0] low_price  = '1;
    logic [PRICE_W-1:0] high_price = '0;
    logic [SUM_W-1:0]   up_sum [NB];
    logic [SUM_W-1:0]   down_sum [NB];
    logic [COLOR_W-1:0] up_tag   = UP_COLOR_RST;
    logic [COLOR_W-1:0] down_tag = DOWN_COLOR_RST;

    volume_by_price_histogram dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // Clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Mostly short gaps, a few long ones; none when idling is off
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [SUM_W-1:0] clip_add(input logic [SUM_W-1:0] acc,
                                                  input logic [VOL_W-1:0] vol);
        logic [SUM_W:0] s;
        s = {1'b0, acc} + (SUM_W + 1)'(vol);
        return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
    endfunction

    // Histogram predictor: store the sample, and on the final one bin the set
    // and queue the 24 bars it produces.
    task automatic take_sample(input logic [PRICE_W-1:0] price,
                               input logic [VOL_W-1:0] vol, input logic fin);
        logic [63:0] lo_q, width_q, base_q, top_q, p_q;
        bar_t        bar;
        bit          rising;
        int          i, k;
        // store full: sample neither stored nor tracked
        if (stored < DEPTH) begin
            price_log[stored] = price;
            vol_log[stored]   = vol;
            stored++;
            if (price < low_price)
                low_price = price;
            if (price > high_price)
                high_price = price;
        end
        if (!fin)
            return;
        width_q = (high_price >= low_price) ?
                  (64'(high_price - low_price) << FRAC_W) / NB : 64'd0;
        lo_q = 64'(low_price) << FRAC_W;
        // first bin holding the price wins; gap prices are dropped
        for (i = 1; i < stored; i++) begin
            p_q    = 64'(price_log[i]) << FRAC_W;
            rising = price_log[i] >= price_log[i-1];
            for (k = 0; k < NB; k++) begin
                base_q = lo_q + 64'(k) * (width_q + GAP_Q);
                if (p_q >= base_q && p_q <= base_q + width_q) begin
                    if (rising)
                        up_sum[k] = clip_add(up_sum[k], vol_log[i]);
                    else
                        down_sum[k] = clip_add(down_sum[k], vol_log[i]);
                    break;
                end
            end
        end
        // two bars per bin: up color first, down color second
        for (k = 0; k < NB; k++) begin
            base_q       = lo_q + 64'(k) * (width_q + GAP_Q);
            top_q        = base_q + width_q;
            bar.bottom   = base_q[FRAC_W +: EDGE_W];
            bar.top      = top_q[FRAC_W +: EDGE_W];
            bar.up_vol   = up_sum[k];
            bar.down_vol = down_sum[k];
            bar.color    = up_tag;
            bar.last     = 1'b0;
            expected_bars.push_back(bar);
            bar.color    = down_tag;
            bar.last     = (k == NB - 1);
            expected_bars.push_back(bar);
        end
        stored     = 0;
        low_price  = '1;
        high_price = '0;
        for (k = 0; k < NB; k++) begin
            up_sum[k]   = '0;
            down_sum[k] = '0;
        end
    endtask

    // Sample driver
    always @(posedge aclk) begin
        sample_t item;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                s_tvalid <= 1'b0;
            end else if (pending_samples.size() > 0) begin
                item = pending_samples.pop_front();
                s_tdata  <= {item.vol, item.price};
                s_tlast  <= item.fin;
                s_tvalid <= 1'b1;
                send_gap <= pick_gap();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Predict on every accepted sample transaction
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            take_sample(s_tdata[PRICE_W-1:0], s_tdata[PRICE_W +: VOL_W], s_tlast);
    end

    // Long receiver hold-off, counted here
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end else if (hold_req) begin
            hold_left <= HOLD_CYCLES;
            hold_req  <= 1'b0;
        end
    end

    // Receiver ready with random stalls
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            m_tready <= 1'b0;
        end else if (recv_wait > 0) begin
            recv_wait <= recv_wait - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready  <= 1'b1;
            recv_wait <= pick_gap();
        end
    end

    // Bar checker
    always @(posedge aclk) begin
        bar_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.bottom   = m_tdata[32:0];
            got.top      = m_tdata[65:33];
            got.up_vol   = m_tdata[107:66];
            got.down_vol = m_tdata[149:108];
            got.color    = m_tdata[173:150];
            got.last     = m_tlast;
            if (expected_bars.size() == 0) begin
                error_count++;
                if (error_count <= 10)
                    $display("unexpected bar: bottom %h top %h up %h down %h color %h last %b",
                             got.bottom, got.top, got.up_vol, got.down_vol, got.color,
                             got.last);
            end else begin
                want = expected_bars.pop_front();
                if (got.bottom !== want.bottom || got.top !== want.top ||
                    got.up_vol !== want.up_vol || got.down_vol !== want.down_vol ||
                    got.color !== want.color || got.last !== want.last) begin
                    error_count++;
                    if (error_count <= 10) begin
                        $display("bar mismatch: exp bottom %h top %h up %h down %h color %h last %b",
                                 want.bottom, want.top, want.up_vol, want.down_vol,
                                 want.color, want.last);
                        $display("              got bottom %h top %h up %h down %h color %h last %b",
                                 got.bottom, got.top, got.up_vol, got.down_vol,
                                 got.color, got.last);
                    end
                end
            end
        end
    end

    task automatic add_sample(input logic [PRICE_W-1:0] price,
                              input logic [VOL_W-1:0] vol, input logic fin);
        sample_t item;
        item.price = price;
        item.vol   = vol;
        item.fin   = fin;
        pending_samples.push_back(item);
    endtask

    // One set of n samples with random content, last one flagged final
    task automatic add_set(input int n, input price_mode_t mode);
        logic [PRICE_W-1:0] base, price;
        logic [VOL_W-1:0]   vol;
        int                 spread, r, i;
        base   = $urandom_range(0, 32'hFFFF_E000);
        spread = $urandom_range(1, 5000);
        for (i = 0; i < n; i++) begin
            case (mode)
                PX_WIDE:   price = $urandom();
                PX_NARROW: price = base + $urandom_range(0, spread);
                default:   price = base;
            endcase
            r = $urandom_range(0, 99);
            if (r < 75)
                vol = $urandom();
            else if (r < 90)
                vol = '1;
            else
                vol = $urandom_range(0, 15);
            add_sample(price, vol, i == n - 1);
        end
    endtask

    // Wait until everything sent has been accepted and every bar has arrived
    task automatic wait_quiet();
        do
            @(negedge aclk);
        while (pending_samples.size() != 0 || s_tvalid || expected_bars.size() != 0);
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic write_color(input cfg_idx_t idx, input logic [COLOR_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == CFG_UP_COLOR)
            up_tag = val;
        else
            down_tag = val;
        @(negedge aclk);
    endtask

    initial begin
        int sent, sets, n, r, i;
        price_mode_t mode;
        for (i = 0; i < NB; i++) begin
            up_sum[i]   = '0;
            down_sum[i] = '0;
        end
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed sets with reset colors
        idle_on = 1'b0;
        // single sample: nothing binned
        add_sample(32'd12345, 32'hFFFF_FFFF, 1'b1);
        // flat set: every bin one point wide
        add_sample(32'd500, 32'd10, 1'b0);
        add_sample(32'd500, 32'd20, 1'b0);
        add_sample(32'd500, 32'd30, 1'b0);
        add_sample(32'd500, 32'd40, 1'b1);
        // price and volume extremes, rising and falling
        add_sample(32'h0000_0000, 32'h0000_0000, 1'b0);
        add_sample(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        add_sample(32'h7FFF_FFFF, 32'h0000_0001, 1'b0);
        add_sample(32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
        add_sample(32'hFFFF_FFFF, 32'h8000_0000, 1'b1);
        // span of 13: price 2 falls in the gap after bin 0
        add_sample(32'd0, 32'd5, 1'b0);
        add_sample(32'd13, 32'd6, 1'b0);
        add_sample(32'd2, 32'd7, 1'b0);
        add_sample(32'd1, 32'd8, 1'b0);
        add_sample(32'd5, 32'd9, 1'b0);
        add_sample(32'd13, 32'd3, 1'b1);
        wait_quiet();

        // Color extremes
        write_color(CFG_UP_COLOR, 24'h000000);
        write_color(CFG_DOWN_COLOR, 24'hFFFFFF);
        idle_on = 1'b1;
        add_set(5, PX_NARROW);
        wait_quiet();
        write_color(CFG_UP_COLOR, 24'hFFFFFF);
        write_color(CFG_DOWN_COLOR, 24'h000000);
        add_set(4, PX_WIDE);
        wait_quiet();

        // Random sets, reconfigured every few sets
        sent = 0;
        sets = 0;
        while (sent < RANDOM_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 70)
                n = $urandom_range(2, 12);
            else if (r < 90)
                n = $urandom_range(13, 40);
            else if (r < 95)
                n = 1;
            else
                n = $urandom_range(41, 120);
            r = $urandom_range(0, 99);
            mode = (r < 30) ? PX_WIDE : (r < 90) ? PX_NARROW : PX_FLAT;
            add_set(n, mode);
            sent += n;
            sets++;
            if (sets % 6 == 0) begin
                wait_quiet();
                write_color(CFG_UP_COLOR, COLOR_W'($urandom()));
                write_color(CFG_DOWN_COLOR, COLOR_W'($urandom()));
                idle_on = ($urandom_range(0, 3) != 0);
            end
        end
        wait_quiet();

        // Receiver holds off while several sets are offered
        idle_on  = 1'b0;
        hold_req = 1'b1;
        add_set(10, PX_NARROW);
        add_set(7, PX_WIDE);
        add_set(12, PX_NARROW);
        wait_quiet();
        repeat (30) @(posedge aclk);

        if (error_count == 0 && expected_bars.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
